// ----- hdl/pcc_pkg.sv -----
package pcc_pkg;

  // Iteration count and arctangent table
  localparam int unsigned DEF_ITERATIONS = 16;
  localparam int unsigned ATAN_LEN       = 24;

  // Datapath formats: x, y carry 14 fraction bits, z is a 32-bit binary angle
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned DW        = 34;
  localparam int unsigned ZW        = 32;

  localparam logic [ZW-1:0] PI_Z = 32'h8000_0000;

  // Inverse of the limiting CORDIC gain, Q0.32, split for two 16-bit partial products
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
  localparam logic [15:0] GAIN_HI  = GAIN_Q32[31:16];
  localparam logic [15:0] GAIN_LO  = GAIN_Q32[15:0];

  // round(atan(2^-i) * 2^31 / pi)
  localparam logic [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic {
    OP_P2C = 1'b0,
    OP_C2P = 1'b1
  } pcc_op_t;

  // One point travelling down the cell row
  typedef struct packed {
    logic                 valid;
    pcc_op_t              op;
    logic                 zero;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [ZW-1:0]        z;
  } pcc_stage_t;

endpackage

// ----- hdl/pcc_prep.sv -----
module pcc_prep
  import pcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  pcc_op_t            op,
  input  logic [14:0]        mag,
  input  logic signed [15:0] angle,
  input  logic signed [15:0] xc,
  input  logic signed [15:0] yc,
  output pcc_stage_t         d_o
);

  pcc_stage_t           st_r, st_nxt;
  logic signed [DW-1:0] xm, xs, ys;
  logic                 fold, lhp;

  always_comb begin
    xm   = {{(DW-15){1'b0}}, mag} <<< FRAC_BITS;
    xs   = {{(DW-16){xc[15]}}, xc};
    ys   = {{(DW-16){yc[15]}}, yc};
    // angles outside +-pi/2 turned by pi: negate start vector
    fold = (angle >= 16'sd16384) || (angle < -16'sd16384);
    lhp  = xc[15];

    st_nxt       = '0;
    st_nxt.valid = acc;
    st_nxt.op    = op;
    unique case (op)
      OP_P2C: begin
        st_nxt.x = fold ? -xm : xm;
        st_nxt.y = '0;
        st_nxt.z = {angle, 16'h0000};
        if (fold) begin
          st_nxt.z[ZW-1] = ~st_nxt.z[ZW-1];
        end
      end
      OP_C2P: begin
        st_nxt.zero = (xc == 16'sd0) && (yc == 16'sd0);
        st_nxt.x    = (lhp ? -xs : xs) <<< FRAC_BITS;
        st_nxt.y    = (lhp ? -ys : ys) <<< FRAC_BITS;
        st_nxt.z    = lhp ? PI_Z : '0;
      end
      default: begin
        st_nxt.x = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_nxt.valid;
    end
    st_r.op   <= st_nxt.op;
    st_r.zero <= st_nxt.zero;
    st_r.x    <= st_nxt.x;
    st_r.y    <= st_nxt.y;
    st_r.z    <= st_nxt.z;
  end

  assign d_o = st_r;

endmodule

// ----- hdl/pcc_cell.sv -----
module pcc_cell
  import pcc_pkg::*;
#(
  parameter int unsigned SHIFT = 0
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  pcc_stage_t d_i,
  output pcc_stage_t d_o
);

  pcc_stage_t           st_r, st_nxt;
  logic signed [DW-1:0] xi, yi, xsh, ysh;
  logic signed [ZW-1:0] zi;
  logic                 ccw;

  always_comb begin
    xi  = d_i.x;
    yi  = d_i.y;
    zi  = $signed(d_i.z);
    xsh = xi >>> SHIFT;
    ysh = yi >>> SHIFT;
    // rotation follows the residual angle, vectoring drives y to zero
    ccw = (d_i.op == OP_C2P) ? yi[DW-1] : ~zi[ZW-1];

    st_nxt = d_i;
    if (ccw) begin
      st_nxt.x = xi - ysh;
      st_nxt.y = yi + xsh;
      st_nxt.z = d_i.z - ATAN_TAB[SHIFT];
    end else begin
      st_nxt.x = xi + ysh;
      st_nxt.y = yi - xsh;
      st_nxt.z = d_i.z + ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r.valid <= st_nxt.valid;
    end
    st_r.op   <= st_nxt.op;
    st_r.zero <= st_nxt.zero;
    st_r.x    <= st_nxt.x;
    st_r.y    <= st_nxt.y;
    st_r.z    <= st_nxt.z;
  end

  assign d_o = st_r;

endmodule

// ----- hdl/pcc_post.sv -----
module pcc_post
  import pcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pcc_stage_t         d_i,
  output logic               out_valid,
  output logic signed [15:0] out_x_out,
  output logic signed [15:0] out_y_out,
  output logic [15:0]        out_mag_out,
  output logic signed [15:0] out_angle_out
);

  localparam int unsigned PW = DW + 17;
  localparam int unsigned SW = DW + 34;
  localparam int unsigned QW = SW - 46;

  localparam logic signed [SW-1:0] RND  = {{(SW-46){1'b0}}, 1'b1, 45'b0};
  localparam logic signed [QW-1:0] QMAX = QW'(32767);
  localparam logic signed [QW-1:0] QMIN = QW'(-32768);
  localparam logic signed [QW-1:0] UMAX = QW'(65535);

  // first stage: partial products against gain halves
  logic                 va_r;
  pcc_op_t              opa_r;
  logic                 zeroa_r;
  logic [15:0]          anga_r;
  logic signed [PW-1:0] pxh_r, pxl_r, pyh_r, pyl_r;
  logic [ZW-1:0]        zrnd;

  // second stage: sum, round, clamp
  logic                 vb_r;
  logic signed [15:0]   xb_r, yb_r, angb_r;
  logic [15:0]          magb_r;
  logic                 vb_nxt;
  logic signed [15:0]   xb_nxt, yb_nxt, angb_nxt;
  logic [15:0]          magb_nxt;
  logic signed [QW-1:0] qx, qy;

  function automatic logic signed [QW-1:0] scale_q(input logic signed [PW-1:0] ph,
                                                   input logic signed [PW-1:0] pl);
    logic signed [SW-1:0] s;
    s = (SW'(ph) <<< 16) + SW'(pl) + RND;
    return s[SW-1:46];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [QW-1:0] q);
    logic signed [15:0] r;
    if (q > QMAX) begin
      r = 16'sh7FFF;
    end else if (q < QMIN) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  assign zrnd = d_i.z + 32'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= d_i.valid;
    end
    opa_r   <= d_i.op;
    zeroa_r <= d_i.zero;
    anga_r  <= zrnd[ZW-1:ZW-16];
    pxh_r   <= d_i.x * $signed({1'b0, GAIN_HI});
    pxl_r   <= d_i.x * $signed({1'b0, GAIN_LO});
    pyh_r   <= d_i.y * $signed({1'b0, GAIN_HI});
    pyl_r   <= d_i.y * $signed({1'b0, GAIN_LO});
  end

  always_comb begin
    qx       = scale_q(pxh_r, pxl_r);
    qy       = scale_q(pyh_r, pyl_r);
    vb_nxt   = va_r;
    xb_nxt   = '0;
    yb_nxt   = '0;
    magb_nxt = '0;
    angb_nxt = '0;
    unique case (opa_r)
      OP_P2C: begin
        xb_nxt = sat16(qx);
        yb_nxt = sat16(qy);
      end
      OP_C2P: begin
        if (!zeroa_r) begin
          if (qx[QW-1]) begin
            magb_nxt = '0;
          end else if (qx > UMAX) begin
            magb_nxt = 16'hFFFF;
          end else begin
            magb_nxt = qx[15:0];
          end
          angb_nxt = anga_r;
        end
      end
      default: begin
        xb_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= vb_nxt;
    end
    xb_r   <= xb_nxt;
    yb_r   <= yb_nxt;
    magb_r <= magb_nxt;
    angb_r <= angb_nxt;
  end

  assign out_valid     = vb_r;
  assign out_x_out     = xb_r;
  assign out_y_out     = yb_r;
  assign out_mag_out   = magb_r;
  assign out_angle_out = angb_r;

endmodule

// ----- hdl/polar_cartesian_converter.sv -----
// Polar/Cartesian converter. One point is taken per clock (start while busy is
// low) and its transaction leaves out_valid high for exactly one cycle, after
// passing the registers in order: the fold of the input into the CORDIC range,
// one register per micro-rotation cell, and the gain multiply and rounding
// stages. The pipeline is fully unrolled, so throughput is one
// transaction per cycle for any mix of opcodes. The receiver cannot stall:
// every result must be taken in the cycle it appears. busy is high only
// while reset is asserted. Fields the opcode does not produce read as zero.
module polar_cartesian_converter
  import pcc_pkg::*;
#(
  parameter int unsigned ITERATIONS = DEF_ITERATIONS
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [14:0]        in_mag_in,
  input  logic signed [15:0] in_angle_in,
  input  logic signed [15:0] in_x_in,
  input  logic signed [15:0] in_y_in,
  output logic               out_valid,
  output logic signed [15:0] out_x_out,
  output logic signed [15:0] out_y_out,
  output logic [15:0]        out_mag_out,
  output logic signed [15:0] out_angle_out
);

  // cell count capped by the arctangent table
  localparam int unsigned NITER = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;

  logic       acc;
  pcc_stage_t chain [NITER+1];

  // no back-pressure anywhere: only reset holds off new transactions
  assign busy = ~rst_n;
  assign acc  = start & ~busy;

  // fold wide angles / left half plane, scale into the datapath format
  pcc_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .op    (pcc_op_t'(in_opcode)),
    .mag   (in_mag_in),
    .angle (in_angle_in),
    .xc    (in_x_in),
    .yc    (in_y_in),
    .d_o   (chain[0])
  );

  // one micro-rotation per cell, shift and arctangent fixed by position
  for (genvar i = 0; i < NITER; i++) begin : g_cell
    pcc_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_i   (chain[i]),
      .d_o   (chain[i+1])
    );
  end

  // gain compensation, rounding, saturation and opcode-dependent fields
  pcc_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .d_i           (chain[NITER]),
    .out_valid     (out_valid),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out),
    .out_mag_out   (out_mag_out),
    .out_angle_out (out_angle_out)
  );

endmodule

// ----- hdl/pcc_checker.sv -----
module pcc_checker
  import pcc_pkg::*;
#(
  parameter int unsigned ITERATIONS = DEF_ITERATIONS
)
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               in_opcode,
  input logic signed [15:0] in_x_in,
  input logic signed [15:0] in_y_in,
  input logic               out_valid,
  input logic signed [15:0] out_x_out,
  input logic signed [15:0] out_y_out,
  input logic [15:0]        out_mag_out,
  input logic signed [15:0] out_angle_out
);

  localparam int unsigned NITER = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;
  localparam int unsigned LAT   = NITER + 3;

  logic       acc;
  logic [5:0] warm_r;

  assign acc = start && !busy;

  // edges since reset release, held at LAT once the pipeline has filled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (warm_r != 6'(LAT)) begin
      warm_r <= warm_r + 6'd1;
    end
  end

  // busy only during reset
  a_busy: assert property (@(posedge clk) busy == !rst_n)
    else $error("busy outside reset");

  // one transaction out for each taken, fixed latency; nothing out while the
  // pipeline still holds only reset-time slots
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == ((warm_r == 6'(LAT)) ? $past(acc, LAT) : 1'b0))
    else $error("result strobe does not match accepted transaction");

  // polar to Cartesian leaves polar outputs clear
  a_p2c: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_opcode, LAT) == OP_P2C))
      |-> (out_mag_out == 16'd0) && (out_angle_out == 16'sd0))
    else $error("polar fields set for polar to Cartesian");

  // Cartesian to polar leaves Cartesian outputs clear
  a_c2p: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_opcode, LAT) == OP_C2P))
      |-> (out_x_out == 16'sd0) && (out_y_out == 16'sd0))
    else $error("Cartesian fields set for Cartesian to polar");

  // origin gives zero magnitude and angle
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_opcode, LAT) == OP_C2P)
      && ($past(in_x_in, LAT) == 16'sd0) && ($past(in_y_in, LAT) == 16'sd0))
      |-> (out_mag_out == 16'd0) && (out_angle_out == 16'sd0))
    else $error("origin not mapped to zero");

endmodule

bind polar_cartesian_converter pcc_checker #(
  .ITERATIONS (ITERATIONS)
) u_pcc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_opcode     (in_opcode),
  .in_x_in       (in_x_in),
  .in_y_in       (in_y_in),
  .out_valid     (out_valid),
  .out_x_out     (out_x_out),
  .out_y_out     (out_y_out),
  .out_mag_out   (out_mag_out),
  .out_angle_out (out_angle_out)
);
